[src/annexb_pkg.sv]
`default_nettype none

package annexb_pkg;

   localparam int CFG_WIDTH    = 24;
   localparam int MAX_RESULTS  = 4;
   localparam int RESULT_CNT_W = 3;
   localparam int RESULT_IDX_W = 2;

   localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 24'd1000000;

   localparam logic       ACTION_BYTE     = 1'b0;
   localparam logic       ACTION_EOS      = 1'b1;
   localparam logic [7:0] START_CODE_BYTE = 8'h01;
   localparam logic [7:0] ZERO_BYTE       = 8'h00;
   localparam logic [1:0] ZERO_RUN_MAX    = 2'd3;
   localparam logic [1:0] ZERO_RUN_CODE   = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       unit_first;
      logic       unit_last;
      logic       unit_empty;
      logic       unit_oversize;
      logic       stream_error;
      logic       run_end;
   } rsp_type;

   // all results caused by one transaction, slot 0 delivered first
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] slot;
      logic [RESULT_CNT_W-1:0]   count;
   } result_set_type;

endpackage

`default_nettype wire

[src/annexb_req_reg.sv]
`default_nettype none

module annexb_req_reg
   import annexb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[src/annexb_parse.sv]
`default_nettype none

module annexb_parse
   import annexb_pkg::*;
#(
   parameter int LENGTH_BITS = 24
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire req_type              item,
   input  wire logic [CFG_WIDTH-1:0] max_len,
   output result_set_type            results
);

   localparam int CMP_W = (LENGTH_BITS > CFG_WIDTH) ? LENGTH_BITS : CFG_WIDTH;

   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic [1:0]             zero_run_ff, zero_run_in;
   logic                   inside_unit_ff, inside_unit_in;
   logic                   first_pending_ff, first_pending_in;
   logic [LENGTH_BITS-1:0] unit_count_ff, unit_count_in;
   logic                   error_seen_ff, error_seen_in;

   logic                    use_held;
   logic [1:0]              n_zeros;
   logic                    mark_last;
   logic                    do_empty;
   logic                    do_error;
   logic                    clr_unit;
   logic                    set_first;
   logic [RESULT_CNT_W-1:0] n_payload;

   function automatic logic [LENGTH_BITS-1:0] sat_add(
      input logic [LENGTH_BITS-1:0]  base,
      input logic [RESULT_CNT_W-1:0] inc
   );
      logic [LENGTH_BITS:0] sum;
      sum = {1'b0, base} + {{(LENGTH_BITS+1-RESULT_CNT_W){1'b0}}, inc};
      if (sum[LENGTH_BITS]) begin
         return {LENGTH_BITS{1'b1}};
      end
      return sum[LENGTH_BITS-1:0];
   endfunction

   function automatic logic over_max(
      input logic [LENGTH_BITS-1:0] cnt,
      input logic [CFG_WIDTH-1:0]   lim
   );
      return CMP_W'(cnt) > CMP_W'(lim);
   endfunction

   // decide what this transaction emits and the next scan state
   always_comb begin
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      zero_run_in    = zero_run_ff;
      inside_unit_in = inside_unit_ff;
      use_held       = 1'b0;
      n_zeros        = 2'd0;
      mark_last      = 1'b0;
      do_empty       = 1'b0;
      do_error       = 1'b0;
      clr_unit       = 1'b0;
      set_first      = 1'b0;

      if (item.action == ACTION_EOS) begin
         if (inside_unit_ff) begin
            if (!held_valid_ff && zero_run_ff == 2'd0) begin
               do_empty = 1'b1;
            end else begin
               use_held  = held_valid_ff;
               n_zeros   = zero_run_ff;
               mark_last = 1'b1;
            end
         end else if (zero_run_ff != 2'd0 && !error_seen_ff) begin
            do_error = 1'b1;
         end
         held_byte_in   = ZERO_BYTE;
         held_valid_in  = 1'b0;
         zero_run_in    = 2'd0;
         inside_unit_in = 1'b0;
         clr_unit       = 1'b1;
      end else if (!inside_unit_ff) begin
         if (item.data_byte == ZERO_BYTE) begin
            if (zero_run_ff < ZERO_RUN_MAX) begin
               zero_run_in = zero_run_ff + 2'd1;
            end else begin
               do_error = !error_seen_ff;
            end
         end else if (item.data_byte == START_CODE_BYTE && zero_run_ff >= ZERO_RUN_CODE) begin
            set_first = 1'b1;
         end else begin
            do_error    = !error_seen_ff;
            zero_run_in = 2'd0;
         end
      end else begin
         if (item.data_byte == ZERO_BYTE) begin
            if (zero_run_ff < ZERO_RUN_MAX) begin
               zero_run_in = zero_run_ff + 2'd1;
            end else begin
               // held byte leaves as payload; the oldest zero of a long run is held
               use_held      = held_valid_ff;
               held_byte_in  = ZERO_BYTE;
               held_valid_in = 1'b1;
            end
         end else if (item.data_byte == START_CODE_BYTE && zero_run_ff >= ZERO_RUN_CODE) begin
            if (!held_valid_ff) begin
               do_empty = 1'b1;
            end else begin
               use_held  = 1'b1;
               mark_last = 1'b1;
            end
            set_first = 1'b1;
         end else begin
            use_held      = held_valid_ff;
            n_zeros       = zero_run_ff;
            held_byte_in  = item.data_byte;
            held_valid_in = 1'b1;
            zero_run_in   = 2'd0;
         end
      end

      // new unit after a start code
      if (set_first) begin
         inside_unit_in = 1'b1;
         zero_run_in    = 2'd0;
         held_valid_in  = 1'b0;
         held_byte_in   = ZERO_BYTE;
         clr_unit       = 1'b1;
      end
   end

   assign n_payload = {2'b00, use_held} + {1'b0, n_zeros};

   always_comb begin
      error_seen_in = error_seen_ff || do_error;
      if (set_first) begin
         first_pending_in = 1'b1;
      end else if (clr_unit || n_payload != '0) begin
         first_pending_in = 1'b0;
      end else begin
         first_pending_in = first_pending_ff;
      end
      if (clr_unit) begin
         unit_count_in = '0;
      end else begin
         unit_count_in = sat_add(unit_count_ff, n_payload);
      end
   end

   // result slots
   always_comb begin
      results = '0;
      if (do_error) begin
         results.count                  = RESULT_CNT_W'(1);
         results.slot[0].stream_error   = 1'b1;
         results.slot[0].run_end        = 1'b1;
      end else if (do_empty) begin
         results.count                  = RESULT_CNT_W'(1);
         results.slot[0].unit_first     = 1'b1;
         results.slot[0].unit_last      = 1'b1;
         results.slot[0].unit_empty     = 1'b1;
         results.slot[0].unit_oversize  = over_max(unit_count_ff, max_len);
         results.slot[0].stream_error   = error_seen_ff;
         results.slot[0].run_end        = 1'b1;
      end else begin
         results.count = n_payload;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (RESULT_CNT_W'(i) < n_payload) begin
               results.slot[i].payload_byte  = (use_held && i == 0) ? held_byte_ff : ZERO_BYTE;
               results.slot[i].unit_first    = first_pending_ff && i == 0;
               results.slot[i].unit_last     = mark_last &&
                                               RESULT_CNT_W'(i + 1) == n_payload;
               results.slot[i].unit_oversize = over_max(
                  sat_add(unit_count_ff, RESULT_CNT_W'(i + 1)), max_len);
               results.slot[i].stream_error  = error_seen_ff;
               results.slot[i].run_end       = RESULT_CNT_W'(i + 1) == n_payload;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff     <= ZERO_BYTE;
         held_valid_ff    <= 1'b0;
         zero_run_ff      <= 2'd0;
         inside_unit_ff   <= 1'b0;
         first_pending_ff <= 1'b0;
         unit_count_ff    <= '0;
         error_seen_ff    <= 1'b0;
      end else if (step) begin
         held_byte_ff     <= held_byte_in;
         held_valid_ff    <= held_valid_in;
         zero_run_ff      <= zero_run_in;
         inside_unit_ff   <= inside_unit_in;
         first_pending_ff <= first_pending_in;
         unit_count_ff    <= unit_count_in;
         error_seen_ff    <= error_seen_in;
      end
   end

endmodule

`default_nettype wire

[src/annexb_rsp_buf.sv]
`default_nettype none

module annexb_rsp_buf
   import annexb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire result_set_type results,
   output logic                free,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data
);

   rsp_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [RESULT_CNT_W-1:0]   rem_ff, rem_in;
   logic [RESULT_IDX_W-1:0]   idx_ff, idx_in;

   assign rsp_valid = rem_ff != '0;
   assign rsp_data  = slot_ff[idx_ff];
   // empty now, or the last held result leaves this cycle
   assign free      = rem_ff == '0 || (rem_ff == RESULT_CNT_W'(1) && rsp_ready);

   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      if (load) begin
         slot_in = results.slot;
         rem_in  = results.count;
         idx_in  = '0;
      end else if (rsp_valid && rsp_ready) begin
         rem_in = rem_ff - RESULT_CNT_W'(1);
         idx_in = idx_ff + RESULT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

[src/annexb_start_code_delimiter_unit.sv]
// Annex B byte stream splitter. Each req transaction carries one stream byte
// or an end-of-stream mark; rsp transactions carry the payload bytes of each
// unit between start codes (00 00 01 or 00 00 00 01), tagged first/last, an
// empty marker for a unit with no payload, an oversize flag once a unit runs
// past max_unit_length bytes, and a sticky error flag once bytes outside a
// unit are no start code. One request gives zero to four responses; run_end
// marks the last. A request with at most one response is taken every cycle
// while rsp_ready is high; while the result buffer drains a larger set one
// per cycle, the next request waits in the input register. The last payload
// byte and up to three zeros are held back until the next byte or end of
// stream decides their fate. The user must write max_unit_length through the
// csr port only while idle; the block itself does not enforce it.
`default_nettype none

module annexb_start_code_delimiter_unit
   import annexb_pkg::*;
#(
   parameter int LENGTH_BITS = 24
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CFG_WIDTH-1:0] csr_data
);

   logic                 item_valid;
   req_type              item;
   logic                 buf_free;
   logic                 step;
   result_set_type       results;
   logic [CFG_WIDTH-1:0] max_len_ff, max_len_in;

   // csr write always taken
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // held request is parsed when the result buffer can take its results
   assign step = item_valid && buf_free;

   // input register parts the req side from the parser
   annexb_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (step),
      .item_valid (item_valid),
      .item       (item)
   );

   // scan state and per-transaction result set
   annexb_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item),
      .max_len (max_len_ff),
      .results (results)
   );

   // result register, drains one response per cycle while rsp_ready is high
   annexb_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .results   (results),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[src/annexb_checker.sv]
`default_nettype none

module annexb_checker
   import annexb_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire req_type              req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire rsp_type              rsp_data,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CFG_WIDTH-1:0] csr_data
);

   logic err_seen_ff, err_seen_in;
   logic in_unit_ff, in_unit_in;
   logic rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      err_seen_in = err_seen_ff || (rsp_fire && rsp_data.stream_error);
      in_unit_in  = in_unit_ff;
      if (rsp_fire && rsp_data.unit_last) begin
         in_unit_in = 1'b0;
      end else if (rsp_fire && rsp_data.unit_first) begin
         in_unit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
         in_unit_ff  <= 1'b0;
      end else begin
         err_seen_ff <= err_seen_in;
         in_unit_ff  <= in_unit_in;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // error flag never drops once reported
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_data.stream_error)
      else $error("stream_error dropped");

   // empty marker is a whole unit with no data
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unit_empty |->
         rsp_data.unit_first && rsp_data.unit_last && rsp_data.payload_byte == ZERO_BYTE)
      else $error("malformed empty marker");

   // a unit is closed before the next one opens
   a_unit_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_unit_ff |-> !rsp_data.unit_first)
      else $error("unit opened before previous closed");

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_ready, req_data, csr_valid, csr_ready, csr_data};

endmodule

bind annexb_start_code_delimiter_unit annexb_checker u_checker (.*);

`default_nettype wire
